// ===== src/neville_polynomial_interpolator_macros.svh =====
// Assertion helpers shared by the interpolator RTL
`ifndef NEVILLE_POLYNOMIAL_INTERPOLATOR_MACROS_SVH
`define NEVILLE_POLYNOMIAL_INTERPOLATOR_MACROS_SVH

// same-cycle implication, off while in reset
`define NPI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define NPI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/npi_pkg.sv =====
package npi_pkg;

  // request modes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_EVAL   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TOO_MANY   = 2'd1;
  localparam logic [1:0] ST_COINCIDENT = 2'd2;
  localparam logic [1:0] ST_NO_POINTS  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_RD,
    S_SETUP,
    S_DIV,
    S_MUL,
    S_COLRD,
    S_COLEND,
    S_DONE
  } state_t;

  // divider request
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  // clamp a 49-bit sum to 48 bits
  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] r;
    if (v[48] != v[47]) begin
      r = v[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  // clamp a 48-bit value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [47:0] v);
    logic [31:0] r;
    if (v[47:31] == {17{v[47]}}) begin
      r = v[31:0];
    end else begin
      r = v[47] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  // apply sign to a magnitude, clamping to the 48-bit range
  function automatic logic signed [47:0] sat_mag(input logic [64:0] m, input logic neg);
    logic [64:0] lim;
    logic [64:0] mc;
    logic [47:0] mag;
    lim = neg ? 65'h8000_0000_0000 : 65'h7FFF_FFFF_FFFF;
    mc  = (m > lim) ? lim : m;
    mag = mc[47:0];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== src/npi_div.sv =====
module npi_div
  import npi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        busy,
  output logic        done,
  output logic [63:0] quot
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] dvd_r;
  logic [33:0] rem_r;
  logic [32:0] dsr_r;
  logic [33:0] trial;
  logic        ge;

  // one restoring step: bring down the next dividend bit
  assign trial = {rem_r[32:0], dvd_r[63]};
  assign ge    = trial >= {1'b0, dsr_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 6'd63);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath: quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? (trial - {1'b0, dsr_r}) : trial;
      dvd_r <= {dvd_r[62:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = dvd_r;

endmodule

// ===== src/neville_polynomial_interpolator.sv =====
// Neville interpolator, signed Q16.16, load-then-query.
// Clear and append are handled directly in S_IDLE. Evaluate over n samples builds
// the tableau one column at a time and registers the result in S_DONE.
// Each tableau update reads in S_RD and S_SETUP, runs the 64-step shared divider, then the 33x24 multiplier.
// One request is worked at a time; a finished result waits in the output register.
// rst_n is synchronous, active low: point set empty, overflow clear, no result held.
`include "neville_polynomial_interpolator_macros.svh"

module neville_polynomial_interpolator
  import npi_pkg::*;
#(
  parameter int MAX_SAMPLES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_x_value,
  input  logic [31:0] in_y_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_interp_value,
  output logic [31:0] out_error_estimate,
  output logic [1:0]  out_status
);

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  // sample and tableau memories
  logic [31:0] x_mem [MAX_SAMPLES];
  logic [31:0] y_mem [MAX_SAMPLES];
  logic [47:0] c_mem [MAX_SAMPLES];
  logic [47:0] d_mem [MAX_SAMPLES];

  logic [31:0] xa_q, xb_q, y_q;
  logic [47:0] c_q, d_q;
  logic [IW-1:0] x_ra, x_rb, c_ra, d_ra, smp_wa, tab_wa;
  logic        smp_we, c_we, d_we;
  logic [47:0] c_wd, d_wd;

  // registers
  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        qx_r, qx_nxt;
  logic [IW-1:0]      i_r, i_nxt;
  logic [IW-1:0]      m_r, m_nxt;
  logic [IW-1:0]      near_r, near_nxt;
  logic [32:0]        best_r, best_nxt;
  logic signed [47:0] y_acc_r, y_acc_nxt;
  logic signed [32:0] da_r, da_nxt;
  logic signed [32:0] db_r, db_nxt;
  logic               div_neg_r, div_neg_nxt;
  logic [47:0]        num_mag_r, num_mag_nxt;
  logic               num_neg_r, num_neg_nxt;
  logic [2:0]         k_r, k_nxt;
  logic [56:0]        p_r, p_nxt;
  logic [80:0]        acc_r, acc_nxt;
  logic [31:0]        res_val_r, res_val_nxt;
  logic [31:0]        res_err_r, res_err_nxt;
  logic [1:0]         res_st_r, res_st_nxt;
  logic [31:0]        out_val_r, out_val_nxt;
  logic [31:0]        out_err_r, out_err_nxt;
  logic [1:0]         out_st_r, out_st_nxt;

  // combinational temporaries
  logic signed [32:0] dist_diff, da_c, db_c, den_c;
  logic [32:0]        dist_c;
  logic signed [47:0] ynear_c, dnum_c, numv_c, dyv_c, ynew_c;
  logic [47:0]        dnum_mag;
  logic [32:0]        den_mag, mul_a;
  logic [23:0]        mul_b;
  logic [56:0]        mul_p;

  div_req_t    div_req;
  logic        div_busy, div_done;
  logic [63:0] div_q;

  npi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  // sample store: append writes, two read ports on x
  always_ff @(posedge clk) begin
    if (smp_we) begin
      x_mem[smp_wa] <= in_x_value;
      y_mem[smp_wa] <= in_y_value;
    end
    xa_q <= x_mem[x_ra];
    xb_q <= x_mem[x_rb];
    y_q  <= y_mem[x_ra];
  end

  // tableau columns
  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[tab_wa] <= c_wd;
    end
    if (d_we) begin
      d_mem[tab_wa] <= d_wd;
    end
    c_q <= c_mem[c_ra];
    d_q <= d_mem[d_ra];
  end

  // shared multiplier, one operand half per cycle
  assign mul_a = (k_r < 3'd2) ? (da_r[32] ? 33'(-da_r) : 33'(da_r))
                              : (db_r[32] ? 33'(-db_r) : 33'(db_r));
  assign mul_b = k_r[0] ? num_mag_r[47:24] : num_mag_r[23:0];
  assign mul_p = 57'(mul_a) * 57'(mul_b);

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    qx_nxt        = qx_r;
    i_nxt         = i_r;
    m_nxt         = m_r;
    near_nxt      = near_r;
    best_nxt      = best_r;
    y_acc_nxt     = y_acc_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    div_neg_nxt   = div_neg_r;
    num_mag_nxt   = num_mag_r;
    num_neg_nxt   = num_neg_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    acc_nxt       = acc_r;
    res_val_nxt   = res_val_r;
    res_err_nxt   = res_err_r;
    res_st_nxt    = res_st_r;
    out_val_nxt   = out_val_r;
    out_err_nxt   = out_err_r;
    out_st_nxt    = out_st_r;

    x_ra   = '0;
    x_rb   = '0;
    c_ra   = '0;
    d_ra   = '0;
    smp_we = 1'b0;
    smp_wa = count_r[IW-1:0];
    c_we   = 1'b0;
    d_we   = 1'b0;
    tab_wa = i_r;
    c_wd   = '0;
    d_wd   = '0;

    div_req          = '0;
    div_req.dividend = '0;

    dist_diff = $signed({xa_q[31], xa_q}) - $signed({qx_r[31], qx_r});
    dist_c    = dist_diff[32] ? 33'(-dist_diff) : 33'(dist_diff);
    ynear_c   = y_acc_r;
    da_c      = $signed({xa_q[31], xa_q}) - $signed({qx_r[31], qx_r});
    db_c      = $signed({xb_q[31], xb_q}) - $signed({qx_r[31], qx_r});
    den_c     = $signed({xa_q[31], xa_q}) - $signed({xb_q[31], xb_q});
    den_mag   = den_c[32] ? 33'(-den_c) : 33'(den_c);
    dnum_c    = sat48($signed({c_q[47], c_q}) - $signed({d_q[47], d_q}));
    dnum_mag  = dnum_c[47] ? 48'(-dnum_c) : 48'(dnum_c);
    numv_c    = sat_mag({1'b0, div_q}, div_neg_r);
    dyv_c     = (near_r != '0) ? $signed(d_q) : $signed(c_q);
    ynew_c    = sat48($signed({y_acc_r[47], y_acc_r}) + $signed({dyv_c[47], dyv_c}));

    // a held result leaves when taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            MODE_CLEAR: begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            MODE_APPEND: begin
              if (count_r >= CW'(MAX_SAMPLES)) begin
                ovf_nxt = 1'b1;
              end else begin
                smp_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_EVAL: begin
              qx_nxt      = in_x_value;
              res_val_nxt = '0;
              res_err_nxt = '0;
              if (count_r == '0) begin
                res_st_nxt = ST_NO_POINTS;
                state_nxt  = S_DONE;
              end else if (ovf_r) begin
                res_st_nxt = ST_TOO_MANY;
                state_nxt  = S_DONE;
              end else begin
                i_nxt     = '0;
                state_nxt = S_INIT;
              end
            end
            default: ;
          endcase
        end
      end

      // nearest-sample search while loading both columns with y
      S_INIT: begin
        c_we = 1'b1;
        d_we = 1'b1;
        c_wd = {{16{y_q[31]}}, y_q};
        d_wd = {{16{y_q[31]}}, y_q};
        x_ra = IW'(CW'(i_r) + 1'b1);
        if (i_r == '0 || dist_c < best_r) begin
          best_nxt = dist_c;
          near_nxt = i_r;
          ynear_c  = {{16{y_q[31]}}, y_q};
        end
        y_acc_nxt = ynear_c;
        i_nxt     = i_r + 1'b1;
        if (CW'(i_r) + 1'b1 == count_r) begin
          if (count_r == CW'(1)) begin
            res_val_nxt = sat32(ynear_c);
            res_err_nxt = sat32(ynear_c);
            res_st_nxt  = ST_OK;
            state_nxt   = S_DONE;
          end else begin
            m_nxt     = IW'(1);
            i_nxt     = '0;
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        x_ra      = i_r;
        x_rb      = i_r + m_r;
        c_ra      = i_r + 1'b1;
        d_ra      = i_r;
        state_nxt = S_SETUP;
      end

      S_SETUP: begin
        if (den_c == '0) begin
          res_val_nxt = '0;
          res_err_nxt = '0;
          res_st_nxt  = ST_COINCIDENT;
          state_nxt   = S_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {dnum_mag, 16'd0};
          div_req.divisor  = den_mag;
          div_neg_nxt      = dnum_c[47] ^ den_c[32];
          da_nxt           = da_c;
          db_nxt           = db_c;
          state_nxt        = S_DIV;
        end
      end

      S_DIV: begin
        if (div_done) begin
          num_neg_nxt = numv_c[47];
          num_mag_nxt = numv_c[47] ? 48'(-numv_c) : 48'(numv_c);
          k_nxt       = '0;
          state_nxt   = S_MUL;
        end
      end

      // two partial products per new entry: lower, then upper
      S_MUL: begin
        k_nxt = k_r + 1'b1;
        if (k_r < 3'd4) begin
          p_nxt = mul_p;
        end
        if (k_r == 3'd1 || k_r == 3'd3) begin
          acc_nxt = 81'(p_r);
        end
        if (k_r == 3'd2 || k_r == 3'd4) begin
          acc_nxt = acc_r + {p_r, 24'd0};
        end
        if (k_r == 3'd3) begin
          c_we = 1'b1;
          c_wd = sat_mag(acc_r[80:16], da_r[32] ^ num_neg_r);
        end
        if (k_r == 3'd5) begin
          d_we = 1'b1;
          d_wd = sat_mag(acc_r[80:16], db_r[32] ^ num_neg_r);
          if (CW'(i_r) + CW'(m_r) + 1'b1 < count_r) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_COLRD;
          end
        end
      end

      S_COLRD: begin
        c_ra      = '0;
        d_ra      = near_r - 1'b1;
        state_nxt = S_COLEND;
      end

      // step the correction path and accumulate
      S_COLEND: begin
        if (near_r != '0) begin
          near_nxt = near_r - 1'b1;
        end
        y_acc_nxt = ynew_c;
        if (CW'(m_r) + 1'b1 < count_r) begin
          m_nxt     = m_r + 1'b1;
          i_nxt     = '0;
          state_nxt = S_RD;
        end else begin
          res_val_nxt = sat32(ynew_c);
          res_err_nxt = sat32(dyv_c);
          res_st_nxt  = ST_OK;
          state_nxt   = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_val_nxt   = res_val_r;
          out_err_nxt   = res_err_r;
          out_st_nxt    = res_st_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    qx_r      <= qx_nxt;
    i_r       <= i_nxt;
    m_r       <= m_nxt;
    near_r    <= near_nxt;
    best_r    <= best_nxt;
    y_acc_r   <= y_acc_nxt;
    da_r      <= da_nxt;
    db_r      <= db_nxt;
    div_neg_r <= div_neg_nxt;
    num_mag_r <= num_mag_nxt;
    num_neg_r <= num_neg_nxt;
    k_r       <= k_nxt;
    p_r       <= p_nxt;
    acc_r     <= acc_nxt;
    res_val_r <= res_val_nxt;
    res_err_r <= res_err_nxt;
    res_st_r  <= res_st_nxt;
    out_val_r <= out_val_nxt;
    out_err_r <= out_err_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_interp_value   = out_val_r;
  assign out_error_estimate = out_err_r;
  assign out_status         = out_st_r;

  `NPI_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(MAX_SAMPLES), "sample count past capacity")
  `NPI_ASSERT_NXT(a_append_grows, clk, rst_n, in_valid && !in_stall && in_mode == MODE_APPEND && count_r < CW'(MAX_SAMPLES), count_r == $past(count_r) + 1'b1, "append did not store sample")
  `NPI_ASSERT_IMP(a_div_start_idle, clk, rst_n, div_req.start, !div_busy, "divider restarted while busy")
  `NPI_ASSERT_NXT(a_result_waits, clk, rst_n, state_r == S_DONE && out_valid_r && out_stall, state_r == S_DONE, "result dropped while output held")

endmodule
